[rtl/aes_pkg.sv]
// shared types, tables and round functions for the aes-128 block
package aes_pkg;

   localparam int NumRounds = 10;
   localparam int BlockWidth = 128;
   localparam int HalfWidth = 64;
   localparam int CsrIndexWidth = 1;

   localparam logic [CsrIndexWidth-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_LOW = 1'b1;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [BlockWidth-1:0] block_type;

   typedef struct packed {
      logic      valid;
      logic      decrypt;
      block_type data;
   } stage_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   localparam logic [7:0] RSBOX [256] = '{
      8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
      8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
      8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
      8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
      8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
      8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
      8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
      8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
      8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
      8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
      8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
      8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
      8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
      8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
      8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
      8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
      8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
      8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
      8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
      8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
      8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
      8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
      8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
      8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
      8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
      8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
      8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
      8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
      8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
      8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
      8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
      8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
   };

   localparam logic [7:0] RCON [NumRounds] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   // byte i of the block (aes numbering) sits at bits 127-8i
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      get_byte = b[BlockWidth-1-8*i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic block_type sub_bytes(input block_type s, input logic inv);
      block_type o;
      for (int i = 0; i < 16; i++) begin
         o[BlockWidth-1-8*i -: 8] = inv ? RSBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
      end
      sub_bytes = o;
   endfunction

   function automatic block_type shift_rows(input block_type s, input logic inv);
      block_type o;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (inv) begin
               o[BlockWidth-1-8*(r+4*((c+r)%4)) -: 8] = get_byte(s, r + 4*c);
            end else begin
               o[BlockWidth-1-8*(r+4*c) -: 8] = get_byte(s, r + 4*((c+r)%4));
            end
         end
      end
      shift_rows = o;
   endfunction

   function automatic block_type mix_columns(input block_type s, input logic inv);
      block_type o;
      logic [7:0] a [4];
      logic [7:0] a2 [4];
      logic [7:0] a4 [4];
      logic [7:0] a8 [4];
      logic [7:0] m2 [4];
      logic [7:0] m3 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k]  = get_byte(s, 4*c + k);
            a2[k] = xtime(a[k]);
            a4[k] = xtime(a2[k]);
            a8[k] = xtime(a4[k]);
            m2[k] = a2[k];
            m3[k] = a2[k] ^ a[k];
            m9[k] = a8[k] ^ a[k];
            mb[k] = a8[k] ^ a2[k] ^ a[k];
            md[k] = a8[k] ^ a4[k] ^ a[k];
            me[k] = a8[k] ^ a4[k] ^ a2[k];
         end
         for (int k = 0; k < 4; k++) begin
            if (inv) begin
               o[BlockWidth-1-8*(4*c+k) -: 8] = me[k] ^ mb[(k+1)%4] ^ md[(k+2)%4]
                                               ^ m9[(k+3)%4];
            end else begin
               o[BlockWidth-1-8*(4*c+k) -: 8] = m2[k] ^ m3[(k+1)%4] ^ a[(k+2)%4]
                                               ^ a[(k+3)%4];
            end
         end
      end
      mix_columns = o;
   endfunction

endpackage

[rtl/aes_if.sv]
// valid/ready channel interfaces for request, response and csr words
interface aes_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [63:0] block_high;
   logic [63:0] block_low;
   modport source (output valid, req_type, block_high, block_low, input ready);
   modport sink (input valid, req_type, block_high, block_low, output ready);
endinterface

interface aes_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_high;
   logic [63:0] out_low;
   modport source (output valid, out_high, out_low, input ready);
   modport sink (input valid, out_high, out_low, output ready);
endinterface

interface aes_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/aes_key_cell.sv]
// one key expansion cell: derives the next round key from the previous
module aes_key_cell #(
   parameter int Round = 0
) (
   input  logic                       clock,
   input  aes_pkg::block_type         key_prev,
   output aes_pkg::block_type         key_next
);
   import aes_pkg::*;

   block_type  key_ff;
   block_type  key_in;
   logic [31:0] w [4];
   logic [31:0] t;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         w[i] = key_prev[BlockWidth-1-32*i -: 32];
      end
      t = {SBOX[w[3][23:16]] ^ RCON[Round], SBOX[w[3][15:8]], SBOX[w[3][7:0]],
           SBOX[w[3][31:24]]};
      key_in[127:96] = w[0] ^ t;
      key_in[95:64]  = w[1] ^ key_in[127:96];
      key_in[63:32]  = w[2] ^ key_in[95:64];
      key_in[31:0]   = w[3] ^ key_in[63:32];
   end

   // registers the next round key; the top holds off words while the key chain settles
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_next = key_ff;
endmodule

[rtl/aes_round_cell.sv]
// one round cell: a combined forward/inverse round with a stage register
module aes_round_cell #(
   parameter int Round = 1,
   parameter int Rounds = aes_pkg::NumRounds
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  aes_pkg::block_type  enc_key,
   input  aes_pkg::block_type  dec_key,
   input  aes_pkg::stage_type  stage_prev,
   output aes_pkg::stage_type  stage_next
);
   import aes_pkg::*;

   localparam bit LastRound = (Round == Rounds);

   stage_type stage_ff;
   stage_type stage_in;
   block_type enc_tmp;
   block_type dec_tmp;

   always_comb begin
      enc_tmp = shift_rows(sub_bytes(stage_prev.data, 1'b0), 1'b0);
      if (!LastRound) begin
         enc_tmp = mix_columns(enc_tmp, 1'b0);
      end
      enc_tmp = enc_tmp ^ enc_key;
      // inverse round: inverse shift and sub, key, then inverse mix
      dec_tmp = sub_bytes(shift_rows(stage_prev.data, 1'b1), 1'b1) ^ dec_key;
      if (!LastRound) begin
         dec_tmp = mix_columns(dec_tmp, 1'b1);
      end
      stage_in = stage_prev;
      stage_in.data = (stage_prev.decrypt == OP_DECRYPT) ? dec_tmp : enc_tmp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.decrypt <= stage_in.decrypt;
         stage_ff.data    <= stage_in.data;
      end
   end

   assign stage_next = stage_ff;
endmodule

[rtl/aes128_block_cipher.sv]
// top level: aes-128 ecb cipher as a chain of round cells
//
//   channel   dir   handshake        word
//   req       in    valid/ready      req_type, block_high, block_low
//   rsp       out   valid/ready      out_high, out_low
//   csr       in    valid/ready      index, data (key_high / key_low)
//
// one word per cycle in while req.ready is high; each word passes through
// an input key-add stage and ten round cells, each one register deep
// the key cells follow the key registers through their own registered chain;
// after reset or a key write req.ready stays low until the settle count reaches zero
// a stall on rsp freezes the stage chain; apart from the key settle count,
// req.ready drops only when the output stage holds a word that is not taken
// reset clears the key registers and all stage valid bits
module aes128_block_cipher #(
   parameter int NumRoundsP = aes_pkg::NumRounds
) (
   input logic    clock,
   input logic    reset,
   aes_req_if.sink   req,
   aes_rsp_if.source rsp,
   aes_csr_if.sink   csr
);
   import aes_pkg::*;

   localparam int SettleWidth = $clog2(NumRoundsP + 1);

   logic [HalfWidth-1:0] key_high_ff;
   logic [HalfWidth-1:0] key_low_ff;

   // rk[0] is the cipher key, rk[r] round key r
   block_type rk [NumRoundsP+1];
   stage_type chain [NumRoundsP+1];
   stage_type entry_in;
   stage_type entry_ff;
   logic      advance;

   // cycles left until the key cells hold the expansion of the current key
   logic [SettleWidth-1:0] settle_ff;
   logic [SettleWidth-1:0] settle_in;
   logic                   key_ready;

   // chain moves unless the last stage holds a word nobody takes
   assign advance   = !chain[NumRoundsP].valid || rsp.ready;
   assign key_ready = (settle_ff == '0);
   assign req.ready = advance && key_ready;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_KEY_HIGH: key_high_ff <= csr.data;
            CSR_KEY_LOW:  key_low_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   // restart the settle count on every key write
   always_comb begin
      settle_in = settle_ff;
      if (csr.valid && csr.ready) begin
         settle_in = SettleWidth'(NumRoundsP);
      end else if (!key_ready) begin
         settle_in = settle_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SettleWidth'(NumRoundsP);
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign rk[0] = {key_high_ff, key_low_ff};

   // key expansion chain
   for (genvar r = 1; r <= NumRoundsP; r++) begin : g_key
      aes_key_cell #(.Round(r - 1)) u_key (
         .clock    (clock),
         .key_prev (rk[r-1]),
         .key_next (rk[r])
      );
   end

   // entry stage: initial add of round key 0 (encrypt) or the last key (decrypt)
   always_comb begin
      entry_in.valid   = req.valid && req.ready;
      entry_in.decrypt = req.req_type;
      entry_in.data    = {req.block_high, req.block_low}
                       ^ ((req.req_type == OP_DECRYPT) ? rk[NumRoundsP] : rk[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff.decrypt <= entry_in.decrypt;
         entry_ff.data    <= entry_in.data;
      end
   end

   assign chain[0] = entry_ff;

   // round cells; decrypt in cell r uses key NumRounds-r
   for (genvar r = 1; r <= NumRoundsP; r++) begin : g_round
      aes_round_cell #(.Round(r), .Rounds(NumRoundsP)) u_round (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .enc_key    (rk[r]),
         .dec_key    (rk[NumRoundsP-r]),
         .stage_prev (chain[r-1]),
         .stage_next (chain[r])
      );
   end

   assign rsp.valid    = chain[NumRoundsP].valid;
   assign rsp.out_high = chain[NumRoundsP].data[BlockWidth-1:HalfWidth];
   assign rsp.out_low  = chain[NumRoundsP].data[HalfWidth-1:0];
endmodule
